>>> hw/rtl/tlbpt_pkg.sv
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared sizes and controller/datapath interface types for the page translator.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

    // address split
    localparam int ADDR_BITS   = 16;
    localparam int OFFSET_BITS = 8;
    localparam int PAGE_BITS   = ADDR_BITS - OFFSET_BITS;
    localparam int PAGE_COUNT  = 1 << PAGE_BITS;

    // physical frames
    localparam int FRAME_BITS  = 8;
    localparam int FRAME_COUNT = 256;
    localparam int FREE_BITS   = FRAME_BITS + 1;

    // tlb geometry
    localparam int TLB_ENTRIES  = 16;
    localparam int TLB_IDX_BITS = 4;

    // statistics counters
    localparam int COUNT_BITS = 16;

    // controller to datapath commands
    typedef struct packed {
        logic load;    // capture address and start page table read
        logic commit;  // resolve lookup, update state, load result
    } tlbpt_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_free;  // result register can take a new transaction
    } tlbpt_status_t;

endpackage

>>> hw/rtl/tlbpt_ctrl.sv
// ----------------------------------------------------------------------------
// tlbpt_ctrl
// Sequencer: accepts one address, then resolves it once the result slot is free.
// ----------------------------------------------------------------------------
module tlbpt_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  tlbpt_pkg::tlbpt_status_t status,
    output tlbpt_pkg::tlbpt_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_LOOKUP = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // handshake and commands
    assign s_ready    = (state_reg == ST_IDLE);
    assign cmd.load   = s_valid && (state_reg == ST_IDLE);
    assign cmd.commit = (state_reg == ST_LOOKUP) && status.out_free;

endmodule

>>> hw/rtl/tlbpt_datapath.sv
// ----------------------------------------------------------------------------
// tlbpt_datapath
// TLB, page table, frame allocator, statistics counters and result register.
// ----------------------------------------------------------------------------
module tlbpt_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  tlbpt_pkg::tlbpt_cmd_t                cmd,
    output tlbpt_pkg::tlbpt_status_t             status,
    input  logic [tlbpt_pkg::ADDR_BITS-1:0]      s_logical_address,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [tlbpt_pkg::ADDR_BITS-1:0]      m_phys_addr,
    output logic [tlbpt_pkg::FRAME_BITS-1:0]     m_frame_id,
    output logic                                 m_tlb_hit,
    output logic                                 m_page_fault,
    output logic [tlbpt_pkg::COUNT_BITS-1:0]     m_hit_total,
    output logic [tlbpt_pkg::COUNT_BITS-1:0]     m_fault_total,
    output logic [tlbpt_pkg::COUNT_BITS-1:0]     m_translation_total
);

    // captured address
    logic [tlbpt_pkg::ADDR_BITS-1:0]   addr_reg;
    logic [tlbpt_pkg::PAGE_BITS-1:0]   page;
    logic [tlbpt_pkg::OFFSET_BITS-1:0] offset;

    // page table
    logic [tlbpt_pkg::PAGE_COUNT-1:0]  page_valid_reg;
    logic [tlbpt_pkg::FRAME_BITS-1:0]  page_frame_reg [tlbpt_pkg::PAGE_COUNT];
    logic [tlbpt_pkg::FRAME_BITS-1:0]  frame_rd_reg;

    // tlb
    logic [tlbpt_pkg::TLB_ENTRIES-1:0] tlb_valid_reg;
    logic [tlbpt_pkg::PAGE_BITS-1:0]   tlb_page_reg  [tlbpt_pkg::TLB_ENTRIES];
    logic [tlbpt_pkg::FRAME_BITS-1:0]  tlb_frame_reg [tlbpt_pkg::TLB_ENTRIES];
    logic [tlbpt_pkg::TLB_IDX_BITS-1:0] fifo_ptr_reg;

    // allocator and counters
    logic [tlbpt_pkg::FREE_BITS-1:0]   free_frame_reg;
    logic [tlbpt_pkg::COUNT_BITS-1:0]  hit_cnt_reg;
    logic [tlbpt_pkg::COUNT_BITS-1:0]  fault_cnt_reg;
    logic [tlbpt_pkg::COUNT_BITS-1:0]  xlat_cnt_reg;
    logic [tlbpt_pkg::COUNT_BITS-1:0]  hit_cnt_next;
    logic [tlbpt_pkg::COUNT_BITS-1:0]  fault_cnt_next;
    logic [tlbpt_pkg::COUNT_BITS-1:0]  xlat_cnt_next;

    // lookup results
    logic [tlbpt_pkg::TLB_ENTRIES-1:0] tlb_match;
    logic                              hit;
    logic                              fault;
    logic                              map_page;
    logic                              fill_tlb;
    logic [tlbpt_pkg::FRAME_BITS-1:0]  tlb_frame_sel;
    logic [tlbpt_pkg::FRAME_BITS-1:0]  frame;

    // result register
    logic                              m_valid_reg;
    logic [tlbpt_pkg::ADDR_BITS-1:0]   phys_reg;
    logic [tlbpt_pkg::FRAME_BITS-1:0]  frame_out_reg;
    logic                              hit_out_reg;
    logic                              fault_out_reg;

    assign page   = addr_reg[tlbpt_pkg::ADDR_BITS-1:tlbpt_pkg::OFFSET_BITS];
    assign offset = addr_reg[tlbpt_pkg::OFFSET_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            addr_reg <= s_logical_address;
        end
    end

    // page table frame store, read on accept, written on allocation
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            frame_rd_reg <= page_frame_reg[
                s_logical_address[tlbpt_pkg::ADDR_BITS-1:tlbpt_pkg::OFFSET_BITS]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && map_page) begin
            page_frame_reg[page] <= frame;
        end
    end

    // associative compare, lowest index wins
    always_comb begin
        tlb_frame_sel = '0;
        for (int i = 0; i < tlbpt_pkg::TLB_ENTRIES; i++) begin
            tlb_match[i] = tlb_valid_reg[i] && (tlb_page_reg[i] == page);
        end
        for (int i = tlbpt_pkg::TLB_ENTRIES - 1; i >= 0; i--) begin
            if (tlb_match[i]) begin
                tlb_frame_sel = tlb_frame_reg[i];
            end
        end
    end

    // resolve hit, walk or fault
    always_comb begin
        hit      = |tlb_match;
        fault    = 1'b0;
        map_page = 1'b0;
        fill_tlb = 1'b0;
        frame    = '0;
        if (hit) begin
            frame = tlb_frame_sel;
        end else if (page_valid_reg[page]) begin
            frame    = frame_rd_reg;
            fill_tlb = 1'b1;
        end else begin
            fault = 1'b1;
            if (free_frame_reg < tlbpt_pkg::FREE_BITS'(tlbpt_pkg::FRAME_COUNT)) begin
                frame    = free_frame_reg[tlbpt_pkg::FRAME_BITS-1:0];
                map_page = 1'b1;
                fill_tlb = 1'b1;
            end
        end
    end

    // saturating statistics
    always_comb begin
        hit_cnt_next   = hit_cnt_reg;
        fault_cnt_next = fault_cnt_reg;
        xlat_cnt_next  = xlat_cnt_reg;
        if (hit && (hit_cnt_reg != '1)) begin
            hit_cnt_next = hit_cnt_reg + 1'b1;
        end
        if (fault && (fault_cnt_reg != '1)) begin
            fault_cnt_next = fault_cnt_reg + 1'b1;
        end
        if (xlat_cnt_reg != '1) begin
            xlat_cnt_next = xlat_cnt_reg + 1'b1;
        end
    end

    // state update on commit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_valid_reg <= '0;
            tlb_valid_reg  <= '0;
            fifo_ptr_reg   <= '0;
            free_frame_reg <= '0;
            hit_cnt_reg    <= '0;
            fault_cnt_reg  <= '0;
            xlat_cnt_reg   <= '0;
        end else if (cmd.commit) begin
            hit_cnt_reg   <= hit_cnt_next;
            fault_cnt_reg <= fault_cnt_next;
            xlat_cnt_reg  <= xlat_cnt_next;
            if (map_page) begin
                page_valid_reg[page] <= 1'b1;
                free_frame_reg       <= free_frame_reg + 1'b1;
            end
            if (fill_tlb) begin
                tlb_valid_reg[fifo_ptr_reg] <= 1'b1;
                fifo_ptr_reg                <= fifo_ptr_reg + 1'b1;
            end
        end
    end

    // tlb payload, no reset needed
    always_ff @(posedge aclk) begin
        if (cmd.commit && fill_tlb) begin
            tlb_page_reg[fifo_ptr_reg]  <= page;
            tlb_frame_reg[fifo_ptr_reg] <= frame;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            phys_reg      <= {frame, offset};
            frame_out_reg <= frame;
            hit_out_reg   <= hit;
            fault_out_reg <= fault;
        end
    end

    assign status.out_free     = !m_valid_reg || m_ready;
    assign m_valid             = m_valid_reg;
    assign m_phys_addr         = phys_reg;
    assign m_frame_id          = frame_out_reg;
    assign m_tlb_hit           = hit_out_reg;
    assign m_page_fault        = fault_out_reg;
    assign m_hit_total         = hit_cnt_reg;
    assign m_fault_total       = fault_cnt_reg;
    assign m_translation_total = xlat_cnt_reg;

endmodule

>>> hw/rtl/tlb_page_table_translator.sv
// Translates a 16-bit logical address (page in bits 15:8, offset in bits 7:0)
// through a 16-entry fully associative TLB with FIFO refill, falling back to a
// 256-entry page table and assigning frames on demand in ascending order. Each
// transaction runs as a capture step, which takes the address and reads the
// page table memory, then a lookup step, which compares the TLB, resolves and
// writes back. A new address is taken in the cycle after the result is loaded,
// so one transaction is resolved before the next is accepted; a result left
// waiting holds the lookup stage. Hit, fault and translation totals saturate.
// ----------------------------------------------------------------------------
// tlb_page_table_translator
// Top level: sequencer plus translation datapath.
// ----------------------------------------------------------------------------
module tlb_page_table_translator (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [tlbpt_pkg::ADDR_BITS-1:0]  s_logical_address,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [tlbpt_pkg::ADDR_BITS-1:0]  m_phys_addr,
    output logic [tlbpt_pkg::FRAME_BITS-1:0] m_frame_id,
    output logic                             m_tlb_hit,
    output logic                             m_page_fault,
    output logic [tlbpt_pkg::COUNT_BITS-1:0] m_hit_total,
    output logic [tlbpt_pkg::COUNT_BITS-1:0] m_fault_total,
    output logic [tlbpt_pkg::COUNT_BITS-1:0] m_translation_total
);

    tlbpt_pkg::tlbpt_cmd_t    cmd;
    tlbpt_pkg::tlbpt_status_t status;

    // sequencer
    tlbpt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // datapath
    tlbpt_datapath u_datapath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .status              (status),
        .s_logical_address   (s_logical_address),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_phys_addr         (m_phys_addr),
        .m_frame_id          (m_frame_id),
        .m_tlb_hit           (m_tlb_hit),
        .m_page_fault        (m_page_fault),
        .m_hit_total         (m_hit_total),
        .m_fault_total       (m_fault_total),
        .m_translation_total (m_translation_total)
    );

endmodule

>>> hw/rtl/tlbpt_checker.sv
// ----------------------------------------------------------------------------
// tlbpt_checker
// Port-level checks for the page translator, bound to the top level.
// ----------------------------------------------------------------------------
module tlbpt_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic [tlbpt_pkg::ADDR_BITS-1:0]  s_logical_address,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [tlbpt_pkg::ADDR_BITS-1:0]  m_phys_addr,
    input logic [tlbpt_pkg::FRAME_BITS-1:0] m_frame_id,
    input logic                             m_tlb_hit,
    input logic                             m_page_fault,
    input logic [tlbpt_pkg::COUNT_BITS-1:0] m_hit_total,
    input logic [tlbpt_pkg::COUNT_BITS-1:0] m_fault_total,
    input logic [tlbpt_pkg::COUNT_BITS-1:0] m_translation_total
);

    // stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_phys_addr)
                                && $stable(m_translation_total))
        else $error("result changed while stalled");

    // a hit is never also flagged as a page fault
    a_hit_no_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_tlb_hit |-> !m_page_fault)
        else $error("transaction flagged as both hit and fault");

    // physical address carries the frame above the offset
    a_frame_field: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_phys_addr[tlbpt_pkg::ADDR_BITS-1:tlbpt_pkg::OFFSET_BITS]
                    == m_frame_id)
        else $error("frame field mismatch");

    // one transaction in flight: no back-to-back accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("address accepted during lookup");

endmodule

bind tlb_page_table_translator tlbpt_checker u_tlbpt_checker (.*);

>>> tb/tlb_page_table_translator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_page_table_translator_tb
// Self-checking bench for the page translator. A directed table and a long
// random run with page locality feed logical addresses. A local TLB and page
// table model predicts each translation, and every result transaction is
// compared field by field. Both sides idle at random, with a long receiver
// hold-off and a full drain pause on the sender side.
// ----------------------------------------------------------------------------
module tlb_page_table_translator_tb;

    // sizes taken from the shared package
    localparam int ADDR_BITS    = tlbpt_pkg::ADDR_BITS;
    localparam int OFFSET_BITS  = tlbpt_pkg::OFFSET_BITS;
    localparam int PAGE_BITS    = tlbpt_pkg::PAGE_BITS;
    localparam int PAGE_COUNT   = tlbpt_pkg::PAGE_COUNT;
    localparam int FRAME_BITS   = tlbpt_pkg::FRAME_BITS;
    localparam int FRAME_COUNT  = tlbpt_pkg::FRAME_COUNT;
    localparam int FREE_BITS    = tlbpt_pkg::FREE_BITS;
    localparam int TLB_ENTRIES  = tlbpt_pkg::TLB_ENTRIES;
    localparam int TLB_IDX_BITS = tlbpt_pkg::TLB_IDX_BITS;
    localparam int COUNT_BITS   = tlbpt_pkg::COUNT_BITS;

    localparam int DIRECTED_ROWS = 24;
    localparam int RANDOM_ITEMS  = 1226;
    localparam int MAX_GAP       = 13;
    localparam int HOLD_AFTER    = 300;
    localparam int HOLD_CYCLES   = 120;
    localparam int PAUSE_AT      = 700;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_LIMIT  = 10;
    localparam int HOT_PAGES     = 8;
    localparam int WARM_PAGES    = 28;

    typedef struct packed {
        logic [ADDR_BITS-1:0]  phys_addr;
        logic [FRAME_BITS-1:0] frame_id;
        logic                  tlb_hit;
        logic                  page_fault;
        logic [COUNT_BITS-1:0] hit_total;
        logic [COUNT_BITS-1:0] fault_total;
        logic [COUNT_BITS-1:0] translation_total;
    } translation_t;

    typedef struct {
        logic [ADDR_BITS-1:0] address;
        bit                   typed;
        translation_t         result;
    } stimulus_row_t;

    // clock, reset and block ports
    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [ADDR_BITS-1:0]  s_logical_address = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [ADDR_BITS-1:0]  m_phys_addr;
    logic [FRAME_BITS-1:0] m_frame_id;
    logic                  m_tlb_hit;
    logic                  m_page_fault;
    logic [COUNT_BITS-1:0] m_hit_total;
    logic [COUNT_BITS-1:0] m_fault_total;
    logic [COUNT_BITS-1:0] m_translation_total;

    // translator state as the bench sees it
    logic                    page_mapped   [PAGE_COUNT];
    logic [FRAME_BITS-1:0]   page_to_frame [PAGE_COUNT];
    logic                    tlb_live      [TLB_ENTRIES];
    logic [PAGE_BITS-1:0]    tlb_tag       [TLB_ENTRIES];
    logic [FRAME_BITS-1:0]   tlb_target    [TLB_ENTRIES];
    logic [TLB_IDX_BITS-1:0] refill_slot;
    logic [FREE_BITS-1:0]    free_frame;
    logic [COUNT_BITS-1:0]   hits_so_far;
    logic [COUNT_BITS-1:0]   faults_so_far;
    logic [COUNT_BITS-1:0]   lookups_so_far;

    translation_t pending_translations[$];
    int           fail_count = 0;
    int           cycle_count = 0;
    bit           sender_idles = 1'b1;
    bit           receiver_idles = 1'b1;

    // directed table: the first rows after reset are typed in, the rest predicted
    stimulus_row_t directed_rows [DIRECTED_ROWS] = '{
        '{16'h0000, 1'b1, '{16'h0000, 8'h00, 1'b0, 1'b1, 16'd0, 16'd1, 16'd1}},
        '{16'h00FF, 1'b1, '{16'h00FF, 8'h00, 1'b1, 1'b0, 16'd1, 16'd1, 16'd2}},
        '{16'hFFFF, 1'b1, '{16'h01FF, 8'h01, 1'b0, 1'b1, 16'd1, 16'd2, 16'd3}},
        '{16'hFF00, 1'b1, '{16'h0100, 8'h01, 1'b1, 1'b0, 16'd2, 16'd2, 16'd4}},
        '{16'h0137, 1'b0, '0},
        '{16'h02C8, 1'b0, '0},
        '{16'h035A, 1'b0, '0},
        '{16'h04A5, 1'b0, '0},
        '{16'h050F, 1'b0, '0},
        '{16'h06F0, 1'b0, '0},
        '{16'h0781, 1'b0, '0},
        '{16'h087E, 1'b0, '0},
        '{16'h0933, 1'b0, '0},
        '{16'h0ACC, 1'b0, '0},
        '{16'h0B55, 1'b0, '0},
        '{16'h0CAA, 1'b0, '0},
        '{16'h0D01, 1'b0, '0},
        '{16'h0EFE, 1'b0, '0},
        '{16'h0F69, 1'b0, '0},
        '{16'h1096, 1'b0, '0},
        '{16'h0012, 1'b0, '0},
        '{16'hFF34, 1'b0, '0},
        '{16'h01E0, 1'b0, '0},
        '{16'h8000, 1'b0, '0}
    };

    tlb_page_table_translator uut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_logical_address   (s_logical_address),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_phys_addr         (m_phys_addr),
        .m_frame_id          (m_frame_id),
        .m_tlb_hit           (m_tlb_hit),
        .m_page_fault        (m_page_fault),
        .m_hit_total         (m_hit_total),
        .m_fault_total       (m_fault_total),
        .m_translation_total (m_translation_total)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // translate one address and update the tlb, page table and totals
    function automatic translation_t translate(input logic [ADDR_BITS-1:0] address);
        translation_t         outcome;
        logic [PAGE_BITS-1:0] page;
        logic [FRAME_BITS-1:0] frame;
        logic                 hit;
        logic                 fault;
        logic                 resolved;
        int                   i;
        page = address[ADDR_BITS-1:OFFSET_BITS];
        frame = '0;
        hit = 1'b0;
        fault = 1'b0;
        resolved = 1'b0;

        // associative search, lowest matching entry wins
        for (i = 0; i < TLB_ENTRIES; i++) begin
            if (!hit && tlb_live[i] && tlb_tag[i] == page) begin
                hit = 1'b1;
                frame = tlb_target[i];
            end
        end

        // tlb miss: page table, demand paging on a fault, then fifo refill
        if (!hit) begin
            if (page_mapped[page]) begin
                frame = page_to_frame[page];
                resolved = 1'b1;
            end else begin
                fault = 1'b1;
                if (free_frame < FRAME_COUNT) begin
                    frame = free_frame[FRAME_BITS-1:0];
                    free_frame = free_frame + 1'b1;
                    page_mapped[page] = 1'b1;
                    page_to_frame[page] = frame;
                    resolved = 1'b1;
                end
            end
            if (resolved) begin
                tlb_live[refill_slot] = 1'b1;
                tlb_tag[refill_slot] = page;
                tlb_target[refill_slot] = frame;
                refill_slot = refill_slot + 1'b1;
            end
        end

        // saturating totals
        if (hit && hits_so_far != '1)
            hits_so_far = hits_so_far + 1'b1;
        if (fault && faults_so_far != '1)
            faults_so_far = faults_so_far + 1'b1;
        if (lookups_so_far != '1)
            lookups_so_far = lookups_so_far + 1'b1;

        outcome.phys_addr         = {frame, address[OFFSET_BITS-1:0]};
        outcome.frame_id          = frame;
        outcome.tlb_hit           = hit;
        outcome.page_fault        = fault;
        outcome.hit_total         = hits_so_far;
        outcome.fault_total       = faults_so_far;
        outcome.translation_total = lookups_so_far;
        return outcome;
    endfunction

    task automatic note_failure(input string message);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, message);
    endtask

    // offer one address, record its translation on acceptance, then idle for a random gap if idling is on
    task automatic offer_address(input logic [ADDR_BITS-1:0] address, input bit typed,
                                 input translation_t typed_result);
        translation_t predicted;
        int           gap;
        @(negedge aclk);
        s_valid = 1'b1;
        s_logical_address = address;
        do @(posedge aclk); while (!s_ready);
        predicted = translate(address);
        pending_translations.push_back(typed ? typed_result : predicted);
        gap = sender_idles ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // compare one result transaction with the oldest pending translation
    task automatic check_translation();
        translation_t want;
        if (pending_translations.size() == 0) begin
            note_failure($sformatf("result with nothing pending, phys_addr %h",
                                   m_phys_addr));
            return;
        end
        want = pending_translations.pop_front();
        if (m_phys_addr !== want.phys_addr)
            note_failure($sformatf("phys_addr expected %h got %h",
                                   want.phys_addr, m_phys_addr));
        if (m_frame_id !== want.frame_id)
            note_failure($sformatf("frame_id expected %h got %h",
                                   want.frame_id, m_frame_id));
        if (m_tlb_hit !== want.tlb_hit)
            note_failure($sformatf("tlb_hit expected %b got %b", want.tlb_hit, m_tlb_hit));
        if (m_page_fault !== want.page_fault)
            note_failure($sformatf("page_fault expected %b got %b",
                                   want.page_fault, m_page_fault));
        if (m_hit_total !== want.hit_total)
            note_failure($sformatf("hit_total expected %0d got %0d",
                                   want.hit_total, m_hit_total));
        if (m_fault_total !== want.fault_total)
            note_failure($sformatf("fault_total expected %0d got %0d",
                                   want.fault_total, m_fault_total));
        if (m_translation_total !== want.translation_total)
            note_failure($sformatf("translation_total expected %0d got %0d",
                                   want.translation_total, m_translation_total));
    endtask

    // result side: random stalls, one long hold-off so the input backs up
    initial begin : result_sink
        int stall;
        int taken;
        taken = 0;
        wait (aresetn);
        forever begin
            if (taken % 64 == 0)
                receiver_idles = ($urandom_range(0, 3) != 0);
            stall = receiver_idles ? $urandom_range(0, MAX_GAP) : 0;
            if (taken == HOLD_AFTER)
                stall = HOLD_CYCLES;
            if (stall > 0) begin
                @(negedge aclk);
                m_ready = 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            check_translation();
            taken++;
        end
    end

    // stimulus and end of run
    initial begin : address_source
        logic [PAGE_BITS-1:0] hot_pages  [HOT_PAGES];
        logic [PAGE_BITS-1:0] warm_pages [WARM_PAGES];
        logic [ADDR_BITS-1:0] address;
        logic [OFFSET_BITS-1:0] offset;
        int                   n;
        int                   k;
        int                   pick;

        // empty tlb and page table, counters cleared
        for (k = 0; k < PAGE_COUNT; k++) begin
            page_mapped[k] = 1'b0;
            page_to_frame[k] = '0;
        end
        for (k = 0; k < TLB_ENTRIES; k++) begin
            tlb_live[k] = 1'b0;
            tlb_tag[k] = '0;
            tlb_target[k] = '0;
        end
        refill_slot = '0;
        free_frame = '0;
        hits_so_far = '0;
        faults_so_far = '0;
        lookups_so_far = '0;

        // assert reset, then release it on a falling edge
        aresetn = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed table
        for (n = 0; n < DIRECTED_ROWS; n++)
            offer_address(directed_rows[n].address, directed_rows[n].typed,
                          directed_rows[n].result);

        // random addresses with page locality: tlb hits, page table hits, new pages
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 150 == 0)
                for (k = 0; k < HOT_PAGES; k++)
                    hot_pages[k] = PAGE_BITS'($urandom);
            if (n % 300 == 0)
                for (k = 0; k < WARM_PAGES; k++)
                    warm_pages[k] = PAGE_BITS'($urandom);
            if (n % 64 == 0)
                sender_idles = ($urandom_range(0, 3) != 0);

            // let everything drain once before carrying on
            if (n == PAUSE_AT) begin
                @(negedge aclk);
                s_valid = 1'b0;
                while (pending_translations.size() != 0) @(posedge aclk);
            end

            offset = OFFSET_BITS'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 45)
                address = {hot_pages[$urandom_range(0, HOT_PAGES - 1)], offset};
            else if (pick < 80)
                address = {warm_pages[$urandom_range(0, WARM_PAGES - 1)], offset};
            else
                address = ADDR_BITS'($urandom);
            offer_address(address, 1'b0, '0);
        end

        @(negedge aclk);
        s_valid = 1'b0;

        // wait for the last results, then a short quiet spell
        while (pending_translations.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pending_translations.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
